[sv/cfr_pkg.sv]
// Package: shared types and codes of the command frame receiver.
package cfr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_CMD_LO  = 4'd1,
    PH_CMD_HI  = 4'd2,
    PH_FLAG    = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CHECK   = 4'd7,
    PH_END     = 4'd8
  } phase_e;

  typedef enum logic [3:0] {
    ROLE_START    = 4'd0,
    ROLE_CMD_LO   = 4'd1,
    ROLE_CMD_HI   = 4'd2,
    ROLE_FLAG     = 4'd3,
    ROLE_LEN_LO   = 4'd4,
    ROLE_LEN_HI   = 4'd5,
    ROLE_PAYLOAD  = 4'd6,
    ROLE_CHECKSUM = 4'd7,
    ROLE_NONE     = 4'd8
  } role_e;

  typedef enum logic [2:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_BAD_END   = 3'd4,
    ST_TOO_LONG  = 3'd5,
    ST_TIMEOUT   = 3'd6
  } status_e;

  // Configuration register indexes
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_WAIT_LIMIT = 2'd2;

  localparam logic [7:0]  START_BYTE_RST = 8'h02;
  localparam logic [7:0]  END_BYTE_RST   = 8'h03;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd3000;

  // Bytes of a frame that are not payload
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
  localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [15:0] wait_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  byte_role;
    logic [15:0] command;
    logic [7:0]  frame_flag;
    logic [15:0] payload_length;
    logic        frame_done;
    logic [2:0]  status;
  } res_t;

endpackage

[sv/cfr_if.sv]
// Interfaces: input, result and configuration channels.
interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface cfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [3:0]  byte_role;
  logic [15:0] command;
  logic [7:0]  frame_flag;
  logic [15:0] payload_length;
  logic        frame_done;
  logic [2:0]  status;

  modport source (output valid, out_byte, byte_role, command, frame_flag, payload_length,
                  frame_done, status, input ready);
  modport sink   (input valid, out_byte, byte_role, command, frame_flag, payload_length,
                  frame_done, status, output ready);
endinterface

interface cfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/command_frame_receiver_core.sv]
// An accepted item goes through the input reg, then the result reg.
// Throughput: one item per cycle unless stalled; one-pass state update per item.
// The result register frees the input side while a finished result waits downstream.
// Reset (rst_ni, async low): parser idle, fields and counters zero, registers to
// start 0x02, end 0x03, timeout 3000 ticks. No clearing pass; ready right after reset.
// Config writes are always taken (ready high); index 3 is ignored.
module command_frame_receiver_core #(
  parameter int MAX_FRAME = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfr_in_if.sink    in_i,
  cfr_out_if.source out_o,
  cfr_cfg_if.sink   cfg_i
);
  import cfr_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= START_BYTE_RST;
      cfg_q.end_byte      <= END_BYTE_RST;
      cfg_q.wait_limit_ms <= WAIT_LIMIT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START_BYTE: cfg_q.start_byte    <= cfg_i.data[7:0];
        REG_END_BYTE:   cfg_q.end_byte      <= cfg_i.data[7:0];
        REG_WAIT_LIMIT: cfg_q.wait_limit_ms <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register
  logic       in_valid_q;
  logic       in_func_q;
  logic [7:0] in_byte_q;
  // Result register
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res;
  logic       advance;  // result slot free or being drained
  logic       step;     // item in input reg goes through the parser

  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_byte_q <= in_i.rx_byte;
    end
  end

  cfr_parser #(
    .MAX_FRAME(MAX_FRAME)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .func_i(in_func_q),
    .byte_i(in_byte_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_res_q <= res;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_byte       = out_res_q.out_byte;
  assign out_o.byte_role      = out_res_q.byte_role;
  assign out_o.command        = out_res_q.command;
  assign out_o.frame_flag     = out_res_q.frame_flag;
  assign out_o.payload_length = out_res_q.payload_length;
  assign out_o.frame_done     = out_res_q.frame_done;
  assign out_o.status         = out_res_q.status;

endmodule

[sv/cfr_parser.sv]
// Frame parser: phase machine, captured fields, checksum and timeout count.
module cfr_parser #(
  parameter int MAX_FRAME = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          func_i,
  input  logic [7:0]    byte_i,
  input  cfr_pkg::cfg_t cfg_i,
  output cfr_pkg::res_t res_o
);
  import cfr_pkg::*;

  localparam int          SeenW    = $clog2(MAX_FRAME);
  localparam logic [16:0] MaxFrame = 17'(MAX_FRAME);

  phase_e            phase_q, phase_d;
  logic [SeenW-1:0]  seen_q, seen_d, seen_inc;
  logic [15:0]       len_q, len_d;
  logic [15:0]       cmd_q, cmd_d;
  logic [7:0]        flag_q, flag_d;
  logic [7:0]        sum_q, sum_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic [3:0]        role;
  logic [2:0]        status;
  logic              done;

  assign seen_inc = seen_q + SeenW'(1);

  always_comb begin
    phase_d   = phase_q;
    seen_d    = seen_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    flag_d    = flag_q;
    sum_d     = sum_q;
    elapsed_d = elapsed_q;
    role      = ROLE_NONE;
    status    = ST_BUSY;
    done      = 1'b0;
    if (func_i) begin
      if (phase_q != PH_IDLE) begin
        if (elapsed_q != ELAPSED_MAX) elapsed_d = elapsed_q + 16'd1;
        if (elapsed_d >= cfg_i.wait_limit_ms) begin
          done    = 1'b1;
          status  = ST_TIMEOUT;
          phase_d = PH_IDLE;
        end
      end
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (byte_i == cfg_i.start_byte) begin
            role      = ROLE_START;
            phase_d   = PH_CMD_LO;
            seen_d    = '0;
            len_d     = '0;
            cmd_d     = '0;
            flag_d    = '0;
            sum_d     = '0;
            elapsed_d = '0;
          end else begin
            done   = 1'b1;
            status = ST_BAD_START;
          end
        end
        PH_CMD_LO: begin
          role    = ROLE_CMD_LO;
          cmd_d   = {8'h00, byte_i};
          sum_d   = sum_q + byte_i;
          phase_d = PH_CMD_HI;
        end
        PH_CMD_HI: begin
          role    = ROLE_CMD_HI;
          cmd_d   = {byte_i, cmd_q[7:0]};
          sum_d   = sum_q + byte_i;
          phase_d = PH_FLAG;
        end
        PH_FLAG: begin
          role    = ROLE_FLAG;
          flag_d  = byte_i;
          sum_d   = sum_q + byte_i;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          role    = ROLE_LEN_LO;
          len_d   = {8'h00, byte_i};
          sum_d   = sum_q + byte_i;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          role   = ROLE_LEN_HI;
          len_d  = {byte_i, len_q[7:0]};
          sum_d  = sum_q + byte_i;
          seen_d = '0;
          if (({1'b0, len_d} + FRAME_OVERHEAD) > MaxFrame) begin
            done    = 1'b1;
            status  = ST_TOO_LONG;
            phase_d = PH_IDLE;
          end else if (len_d == 16'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          role   = ROLE_PAYLOAD;
          sum_d  = sum_q + byte_i;
          seen_d = seen_inc;
          if (16'(seen_inc) >= len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          role    = ROLE_CHECKSUM;
          sum_d   = sum_q + byte_i;
          phase_d = PH_END;
        end
        default: begin
          done = 1'b1;
          if (byte_i != cfg_i.end_byte) status = ST_BAD_END;
          else if (sum_q != 8'h00)      status = ST_BAD_SUM;
          else                          status = ST_OK;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      seen_q    <= '0;
      len_q     <= '0;
      cmd_q     <= '0;
      flag_q    <= '0;
      sum_q     <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      seen_q    <= seen_d;
      len_q     <= len_d;
      cmd_q     <= cmd_d;
      flag_q    <= flag_d;
      sum_q     <= sum_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign res_o.out_byte       = func_i ? 8'h00 : byte_i;
  assign res_o.byte_role      = role;
  assign res_o.command        = cmd_d;
  assign res_o.frame_flag     = flag_d;
  assign res_o.payload_length = len_d;
  assign res_o.frame_done     = done;
  assign res_o.status         = status;

endmodule
